/* rtl/assert_macros.svh */
// Assertion helpers for the RTL files that check themselves.
// Each macro expects a clock named clk and an active-high reset named rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define V3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define V3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/v3alu_pkg.sv */
package v3alu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;                 // vector component width
  localparam int SW        = 48;                 // scalar result width
  localparam int OP_W      = 4;
  localparam int PW        = 2 * DW;             // full product width
  localparam int RT_W      = DW;                 // square root width
  localparam int SQ_W      = 2 * RT_W;           // radicand width
  localparam int DQ_W      = DW + FRAC_BITS;     // dividend and quotient width
  localparam int DV_W      = DW;                 // divisor width
  localparam int IN_W      = 7 * DW;
  localparam int OUT_W     = ((3 * DW + SW + 2 + 7) / 8) * 8;

  localparam logic signed [PW-1:0] DW_MAX = (PW'(1) <<< (DW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] DW_MIN = -DW_MAX - PW'(1);
  localparam logic signed [PW-1:0] SW_MAX = (PW'(1) <<< (SW - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SW_MIN = -SW_MAX - PW'(1);

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_SCALE = 4'd3,
    OP_DIV   = 4'd4,
    OP_LEN   = 4'd5,
    OP_NORM  = 4'd6,
    OP_DOT   = 4'd7,
    OP_CROSS = 4'd8
  } op_t;

  // Payload that rides alongside the square root pipeline.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [2:0][DW-1:0] a;
    logic [DW-1:0]      sdiv;
    logic [2:0][DW-1:0] r;
    logic [SW-1:0]      sc;
    logic               ovf;
  } sq_pay_t;

  // Payload that rides alongside the divider pipeline.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [2:0][DW-1:0] r;
    logic [SW-1:0]      sc;
    logic               ovf;
    logic               dz;
    logic [2:0]         neg;
  } dv_pay_t;

  // Returns {overflow, value} saturated to a component.
  function automatic logic [DW:0] sat_dw(input logic signed [PW-1:0] v);
    logic [DW:0] res;
    if (v > DW_MAX) begin
      res = {1'b1, DW_MAX[DW-1:0]};
    end else if (v < DW_MIN) begin
      res = {1'b1, DW_MIN[DW-1:0]};
    end else begin
      res = {1'b0, v[DW-1:0]};
    end
    return res;
  endfunction

  // Returns {overflow, value} saturated to the scalar result.
  function automatic logic [SW:0] sat_sw(input logic signed [PW-1:0] v);
    logic [SW:0] res;
    if (v > SW_MAX) begin
      res = {1'b1, SW_MAX[SW-1:0]};
    end else if (v < SW_MIN) begin
      res = {1'b1, SW_MIN[SW-1:0]};
    end else begin
      res = {1'b0, v[SW-1:0]};
    end
    return res;
  endfunction

  function automatic logic [DW-1:0] mag_dw(input logic [DW-1:0] v);
    return v[DW-1] ? (~v + DW'(1)) : v;
  endfunction

endpackage

/* rtl/vec3_fixed_point_alu_unit.sv */
// Three-component vector unit in signed fixed point (16 fraction bits).
// Input transactions arrive on the s_ channel: s_tuser carries the operation
// code, s_tdata the vectors a and b and the scalar. Each input transaction
// produces exactly one result transaction on the m_ channel.
// The unit is one pipeline of 85 register stages: four for operand capture,
// multiplication, summing and saturation, 32 for the square root (one root
// bit per stage), 48 for the divider (one quotient bit per stage, three
// lanes) and the output register. Every operation takes the same path. The
// capture stage loads at the accepting edge; results leave in input order.
// Throughput is one transaction per cycle while m_tready stays high.
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears every stage's valid bit; the data registers are not reset.
`include "assert_macros.svh"

module vec3_fixed_point_alu_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
  input  logic [v3alu_pkg::IN_W-1:0]    s_tdata,
  // req_type
  input  logic [v3alu_pkg::OP_W-1:0]    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // r_x, r_y, r_z, scalar_out, div_zero, overflow, zero fill
  output logic [v3alu_pkg::OUT_W-1:0]   m_tdata
);
  import v3alu_pkg::*;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Operand capture.
  logic                   v1;
  logic [OP_W-1:0]        op1;
  logic signed [DW-1:0]   a1 [3];
  logic signed [DW-1:0]   b1 [3];
  logic signed [DW-1:0]   s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1 <= s_tuser;
      for (int i = 0; i < 3; i++) begin
        a1[i] <= s_tdata[DW*i +: DW];
        b1[i] <= s_tdata[DW*(3+i) +: DW];
      end
      s1 <= s_tdata[DW*6 +: DW];
    end
  end

  // Multiplier operand selection. The cross product uses all six units.
  logic signed [DW-1:0] ma [6];
  logic signed [DW-1:0] mb [6];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[i] = a1[i];
      mb[i] = b1[i];
    end
    ma[3] = a1[0]; mb[3] = b1[2];
    ma[4] = a1[0]; mb[4] = b1[1];
    ma[5] = a1[1]; mb[5] = b1[0];
    unique case (op1)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) mb[i] = s1;
      end
      OP_LEN, OP_NORM: begin
        for (int i = 0; i < 3; i++) mb[i] = a1[i];
      end
      OP_CROSS: begin
        ma[0] = a1[1]; mb[0] = b1[2];
        ma[1] = a1[2]; mb[1] = b1[1];
        ma[2] = a1[2]; mb[2] = b1[0];
      end
      default: begin
      end
    endcase
  end

  // Products.
  logic                   v2;
  logic [OP_W-1:0]        op2;
  logic signed [PW-1:0]   p2 [6];
  logic signed [DW-1:0]   a2 [3];
  logic signed [DW-1:0]   b2 [3];
  logic signed [DW-1:0]   s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2 <= op1;
      for (int i = 0; i < 6; i++) p2[i] <= PW'(ma[i]) * PW'(mb[i]);
      for (int i = 0; i < 3; i++) begin
        a2[i] <= a1[i];
        b2[i] <= b1[i];
      end
      s2 <= s1;
    end
  end

  // Sums and differences at full width, before saturation.
  logic signed [PW-1:0] sh [6];
  logic signed [PW-1:0] vr [3];
  logic signed [PW-1:0] vsc;
  logic [SQ_W-1:0]      sumsq;

  always_comb begin
    for (int i = 0; i < 6; i++) sh[i] = p2[i] >>> FRAC_BITS;
    for (int i = 0; i < 3; i++) vr[i] = '0;
    vsc   = '0;
    sumsq = SQ_W'(p2[0]) + SQ_W'(p2[1]) + SQ_W'(p2[2]);
    unique case (op2)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) vr[i] = PW'(a2[i]) + PW'(b2[i]);
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) vr[i] = PW'(a2[i]) - PW'(b2[i]);
      end
      OP_MUL, OP_SCALE: begin
        for (int i = 0; i < 3; i++) vr[i] = sh[i];
      end
      OP_DOT: begin
        vsc = sh[0] + sh[1] + sh[2];
      end
      OP_CROSS: begin
        vr[0] = sh[0] - sh[1];
        vr[1] = sh[2] - sh[3];
        vr[2] = sh[4] - sh[5];
      end
      default: begin
      end
    endcase
  end

  logic                   v3;
  logic [OP_W-1:0]        op3;
  logic signed [PW-1:0]   vr3 [3];
  logic signed [PW-1:0]   vsc3;
  logic [SQ_W-1:0]        sumsq3;
  logic signed [DW-1:0]   a3 [3];
  logic signed [DW-1:0]   s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3    <= op2;
      vr3    <= vr;
      vsc3   <= vsc;
      sumsq3 <= sumsq;
      a3     <= a2;
      s3     <= s2;
    end
  end

  // Saturation of the operations that need neither root nor quotient.
  sq_pay_t      pay_next;
  logic [DW:0]  satr [3];
  logic [SW:0]  sats;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      satr[i]      = sat_dw(vr3[i]);
      pay_next.a[i] = a3[i];
      pay_next.r[i] = satr[i][DW-1:0];
    end
    sats          = sat_sw(vsc3);
    pay_next.op   = op3;
    pay_next.sdiv = s3;
    pay_next.sc   = sats[SW-1:0];
    pay_next.ovf  = satr[0][DW] | satr[1][DW] | satr[2][DW] | sats[SW];
  end

  logic            v4;
  logic [SQ_W-1:0] rad4;
  sq_pay_t         pay4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad4 <= sumsq3;
      pay4 <= pay_next;
    end
  end

  logic            sq_valid;
  logic [RT_W-1:0] sq_root;
  sq_pay_t         sq_pay;

  v3alu_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .in_rad    (rad4),
    .in_pay    (pay4),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_pay   (sq_pay)
  );

  // Divider setup: magnitudes in, signs carried beside.
  logic [2:0][DQ_W-1:0] dv_num;
  logic [DV_W-1:0]      dv_den;
  dv_pay_t              dv_in_pay;
  logic                 is_div_op;
  logic                 is_quo_op;

  always_comb begin
    is_div_op = (sq_pay.op == OP_DIV);
    is_quo_op = is_div_op || (sq_pay.op == OP_NORM);
    dv_den    = is_div_op ? mag_dw(sq_pay.sdiv) : sq_root;
    for (int i = 0; i < 3; i++) begin
      dv_num[i]        = {mag_dw(sq_pay.a[i]), FRAC_BITS'(0)};
      dv_in_pay.neg[i] = sq_pay.a[i][DW-1] ^ (is_div_op & sq_pay.sdiv[DW-1]);
    end
    dv_in_pay.op  = sq_pay.op;
    dv_in_pay.r   = sq_pay.r;
    dv_in_pay.sc  = (sq_pay.op == OP_LEN) ? SW'(sq_root) : sq_pay.sc;
    dv_in_pay.ovf = sq_pay.ovf;
    dv_in_pay.dz  = is_quo_op && (dv_den == '0);
  end

  logic                 dv_valid;
  logic [2:0][DQ_W-1:0] dv_quo;
  dv_pay_t              dv_pay;

  v3alu_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_valid),
    .in_num    (dv_num),
    .in_den    (dv_den),
    .in_pay    (dv_in_pay),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_pay   (dv_pay)
  );

  // Final selection and quotient saturation.
  logic [2:0][DW-1:0]   fin_r;
  logic                 fin_ovf;
  logic signed [PW-1:0] qs;
  logic [DW:0]          qsat;
  logic                 out_quo_op;

  always_comb begin
    out_quo_op = (dv_pay.op == OP_DIV) || (dv_pay.op == OP_NORM);
    fin_r      = dv_pay.r;
    fin_ovf    = dv_pay.ovf;
    qs         = '0;
    qsat       = '0;
    if (out_quo_op) begin
      for (int i = 0; i < 3; i++) begin
        qs   = dv_pay.neg[i] ? -PW'(dv_quo[i]) : PW'(dv_quo[i]);
        qsat = sat_dw(qs);
        if (dv_pay.dz) begin
          fin_r[i] = '0;
        end else begin
          fin_r[i] = qsat[DW-1:0];
          fin_ovf  = fin_ovf | qsat[DW];
        end
      end
    end
  end

  logic [2:0][DW-1:0] r_out;
  logic [SW-1:0]      sc_out;
  logic               dz_out;
  logic               ovf_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out   <= fin_r;
      sc_out  <= dv_pay.sc;
      dz_out  <= dv_pay.dz;
      ovf_out <= fin_ovf;
    end
  end

  assign m_tdata = OUT_W'({ovf_out, dz_out, sc_out, r_out[2], r_out[1], r_out[0]});

  // A stalled result must freeze the input side as well.
  `V3_ASSERT_IMP(a_stall_blocks_input, m_tvalid && !m_tready, !s_tready,
                 "input accepted while a result is stalled")
  // A zero divisor clears the vector and leaves no scalar.
  `V3_ASSERT_IMP(a_dz_zero_result, m_tvalid && dz_out,
                 (r_out == '0) && (sc_out == '0),
                 "divide flag with nonzero result")
  // An accepted transaction enters the first stage.
  `V3_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, v1,
                 "accepted transaction missing from first stage")

endmodule

/* rtl/v3alu_sqrt.sv */
module v3alu_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [v3alu_pkg::SQ_W-1:0] in_rad,
  input  v3alu_pkg::sq_pay_t         in_pay,
  output logic                       out_valid,
  output logic [v3alu_pkg::RT_W-1:0] out_root,
  output v3alu_pkg::sq_pay_t         out_pay
);
  import v3alu_pkg::*;

  // One root bit per stage; entry 0 of each array is the pipeline input.
  logic            vld  [0:RT_W];
  logic [SQ_W-1:0] rad  [0:RT_W];
  logic [RT_W+1:0] rem  [0:RT_W];
  logic [RT_W-1:0] root [0:RT_W];
  sq_pay_t         pay  [0:RT_W];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign pay[0]  = in_pay;

  for (genvar k = 0; k < RT_W; k++) begin : g_step
    logic [RT_W+3:0] cur;
    logic [RT_W+3:0] trial;
    logic [RT_W+3:0] diff;
    logic            take;

    assign cur   = {rem[k], rad[k][SQ_W-1 -: 2]};
    assign trial = {2'b00, root[k], 2'b01};
    assign diff  = cur - trial;
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[k+1]  <= rad[k] << 2;
        rem[k+1]  <= take ? diff[RT_W+1:0] : cur[RT_W+1:0];
        root[k+1] <= {root[k][RT_W-2:0], take};
        pay[k+1]  <= pay[k];
      end
    end
  end

  assign out_valid = vld[RT_W];
  assign out_root  = root[RT_W];
  assign out_pay   = pay[RT_W];

endmodule

/* rtl/v3alu_div.sv */
module v3alu_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [2:0][v3alu_pkg::DQ_W-1:0]     in_num,
  input  logic [v3alu_pkg::DV_W-1:0]          in_den,
  input  v3alu_pkg::dv_pay_t                  in_pay,
  output logic                                out_valid,
  output logic [2:0][v3alu_pkg::DQ_W-1:0]     out_quo,
  output v3alu_pkg::dv_pay_t                  out_pay
);
  import v3alu_pkg::*;

  // Restoring division, one quotient bit per stage for all three lanes.
  // The dividend shifts out of num at the top while quotient bits enter below.
  logic                       vld [0:DQ_W];
  logic [2:0][DQ_W-1:0]       num [0:DQ_W];
  logic [2:0][DV_W-1:0]       rem [0:DQ_W];
  logic [DV_W-1:0]            den [0:DQ_W];
  dv_pay_t                    pay [0:DQ_W];

  assign vld[0] = in_valid;
  assign num[0] = in_num;
  assign rem[0] = '0;
  assign den[0] = in_den;
  assign pay[0] = in_pay;

  for (genvar k = 0; k < DQ_W; k++) begin : g_step
    logic [2:0][DQ_W-1:0] num_next;
    logic [2:0][DV_W-1:0] rem_next;

    always_comb begin
      logic [DV_W:0] cur;
      logic [DV_W:0] diff;
      logic          take;
      for (int l = 0; l < 3; l++) begin
        cur         = {rem[k][l], num[k][l][DQ_W-1]};
        diff        = cur - {1'b0, den[k]};
        take        = (cur >= {1'b0, den[k]});
        rem_next[l] = take ? diff[DV_W-1:0] : cur[DV_W-1:0];
        num_next[l] = {num[k][l][DQ_W-2:0], take};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[k+1] <= num_next;
        rem[k+1] <= rem_next;
        den[k+1] <= den[k];
        pay[k+1] <= pay[k];
      end
    end
  end

  assign out_valid = vld[DQ_W];
  assign out_quo   = num[DQ_W];
  assign out_pay   = pay[DQ_W];

endmodule
